[rtl/assert_macros.svh]
// Assertion macros for the overlay generator top level, clocked on clock and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("concurrent assertion failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("concurrent assertion failed");

`endif

[rtl/atog_pkg.sv]
// Package with the constants, font tables and types of the alert text overlay generator.
package atog_pkg;

   localparam int TEXT_SCALE = 3;
   localparam int MAX_DIM    = 4096;

   localparam int DIM_W   = 13;
   localparam int COORD_W = 12;
   localparam int ACT_W   = 2;
   localparam int HOLD_W  = 8;
   localparam int COLOR_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [ACT_W-1:0] ACT_PIXEL   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TRIGGER = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TICK    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_AREA_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_LENGTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLED     = 2'd3;

   localparam logic [DIM_W-1:0]  RESET_WIDTH  = 13'd320;
   localparam logic [DIM_W-1:0]  RESET_HEIGHT = 13'd64;
   localparam logic [HOLD_W-1:0] RESET_HOLD   = 8'd15;

   localparam logic [COLOR_W-1:0] COLOR_BG     = 32'hC0B0_2020;
   localparam logic [COLOR_W-1:0] COLOR_TEXT   = 32'hFFFF_FFFF;
   localparam logic [COLOR_W-1:0] COLOR_BORDER = 32'hFFFF_FF00;
   localparam logic [COLOR_W-1:0] COLOR_CLEAR  = 32'h0000_0000;

   localparam int GLYPH_W     = 5;
   localparam int GLYPH_H     = 7;
   localparam int GLYPH_PITCH = 6;
   localparam int GLYPH_COUNT = 10;
   localparam int TEXT_LEN    = 16;
   localparam int MARGIN      = 4;

   localparam int CELL_W = GLYPH_PITCH * TEXT_SCALE;
   localparam int TEXT_W = TEXT_LEN * CELL_W;
   localparam int TEXT_H = GLYPH_H * TEXT_SCALE;

   localparam int DX_W    = $clog2(TEXT_W);
   localparam int DY_W    = $clog2(TEXT_H);
   localparam int IDX_W   = $clog2(TEXT_LEN);
   localparam int Q_W     = $clog2(TEXT_LEN * GLYPH_PITCH);
   localparam int COL_W   = $clog2(GLYPH_PITCH);
   localparam int ROW_W   = $clog2(GLYPH_H);
   localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
   localparam int BIT_W   = $clog2(GLYPH_W);

   // Division by a constant is done as a multiply by a rounded-up reciprocal.
   localparam int DIV_SH      = 20;
   localparam int RECIP_W     = DIV_SH + 1;
   localparam int RECIP_SCALE = (2 ** DIV_SH + TEXT_SCALE - 1) / TEXT_SCALE;
   localparam int RECIP_CELL  = (2 ** DIV_SH + CELL_W - 1) / CELL_W;

   localparam logic [GLYPH_W-1:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_H] = '{
      '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
      '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
      '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
      '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
      '{5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F},
      '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04},
      '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}
   };

   // The banner text as glyph numbers, the space being the blank glyph.
   localparam logic [GLYPH_IDX_W-1:0] TEXT_GLYPHS [TEXT_LEN] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd1, 4'd4, 4'd9, 4'd5,
      4'd6, 4'd2, 4'd6, 4'd7, 4'd2, 4'd6, 4'd5, 4'd8
   };

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] width_m1;
      logic [DIM_W-1:0] height_m1;
      logic [DIM_W-1:0] start_x;
      logic [DIM_W-1:0] start_y;
   } atog_geom_type;

endpackage

[rtl/atog_pixel_shade.sv]
// Combinational colour of one overlay pixel: text over border over background, clear when hidden or outside the area.
module atog_pixel_shade (
   input  atog_pkg::atog_geom_type          geom,
   input  logic                             shown,
   input  logic [atog_pkg::COORD_W-1:0]     pixel_x,
   input  logic [atog_pkg::COORD_W-1:0]     pixel_y,
   output logic [atog_pkg::COLOR_W-1:0]     pixel_color
);
   import atog_pkg::*;

   localparam int PROD_X_W = DX_W + RECIP_W;
   localparam int PROD_Y_W = DY_W + RECIP_W;

   logic [DIM_W-1:0]        x_ext;
   logic [DIM_W-1:0]        y_ext;
   logic [DIM_W-1:0]        dx_full;
   logic [DIM_W-1:0]        dy_full;
   logic                    in_text;
   logic [DX_W-1:0]         dx;
   logic [DY_W-1:0]         dy;
   logic [PROD_X_W-1:0]     prod_q;
   logic [PROD_X_W-1:0]     prod_idx;
   logic [PROD_Y_W-1:0]     prod_row;
   logic [Q_W-1:0]          q;
   logic [IDX_W-1:0]        idx;
   logic [Q_W-1:0]          q_base;
   logic [COL_W-1:0]        col;
   logic [ROW_W-1:0]        row;
   logic [GLYPH_W-1:0]      row_bits;
   logic [BIT_W-1:0]        bit_sel;
   logic                    text_on;
   logic                    in_area;
   logic                    on_border;

   always_comb begin
      x_ext   = DIM_W'(pixel_x);
      y_ext   = DIM_W'(pixel_y);
      dx_full = x_ext - geom.start_x;
      dy_full = y_ext - geom.start_y;
      in_text = (x_ext >= geom.start_x) && (y_ext >= geom.start_y) &&
                (dx_full < DIM_W'(TEXT_W)) && (dy_full < DIM_W'(TEXT_H));
      dx = dx_full[DX_W-1:0];
      dy = dy_full[DY_W-1:0];

      prod_q   = PROD_X_W'(dx) * PROD_X_W'(RECIP_SCALE);
      prod_idx = PROD_X_W'(dx) * PROD_X_W'(RECIP_CELL);
      prod_row = PROD_Y_W'(dy) * PROD_Y_W'(RECIP_SCALE);
      q   = Q_W'(prod_q >> DIV_SH);
      idx = IDX_W'(prod_idx >> DIV_SH);
      row = ROW_W'(prod_row >> DIV_SH);

      q_base = Q_W'(idx * GLYPH_PITCH);
      col    = COL_W'(q - q_base);

      row_bits = GLYPH_ROM[TEXT_GLYPHS[idx]][row];
      bit_sel  = BIT_W'(GLYPH_W - 1) - BIT_W'(col);
      text_on  = in_text && (col < COL_W'(GLYPH_W)) && (row < ROW_W'(GLYPH_H)) &&
                 row_bits[bit_sel];

      in_area   = (x_ext < geom.width) && (y_ext < geom.height);
      on_border = (pixel_x == '0) || (pixel_y == '0) ||
                  (x_ext == geom.width_m1) || (y_ext == geom.height_m1);

      if (!shown || !in_area) begin
         pixel_color = COLOR_CLEAR;
      end else if (text_on) begin
         pixel_color = COLOR_TEXT;
      end else if (on_border) begin
         pixel_color = COLOR_BORDER;
      end else begin
         pixel_color = COLOR_BG;
      end
   end

endmodule

[rtl/alert_text_overlay_generator.sv]
// Alert banner overlay generator: request register, pixel shading and result register.
// One request is accepted per clock while req_stall is low; it passes through the request
// register and then the result register, with the pixel path shaded combinationally between
// those two registers. Every request gives one result: the ARGB colour for a pixel query
// and transparent for any other action, plus the banner state after the request. The text
// position is worked out when the area size is written, so configuration writes take effect
// at once and csr_ready is always high.
module alert_text_overlay_generator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [atog_pkg::ACT_W-1:0]      req_action,
   input  logic [atog_pkg::COORD_W-1:0]    req_pixel_x,
   input  logic [atog_pkg::COORD_W-1:0]    req_pixel_y,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [atog_pkg::COLOR_W-1:0]    rsp_pixel_color,
   output logic                            rsp_alert_shown,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [atog_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [atog_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import atog_pkg::*;
`include "assert_macros.svh"

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [ACT_W-1:0]      s1_action_ff;
   logic [COORD_W-1:0]    s1_x_ff;
   logic [COORD_W-1:0]    s1_y_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [COLOR_W-1:0]    rsp_color_ff;
   logic [COLOR_W-1:0]    rsp_color_in;
   logic                  rsp_shown_ff;
   logic                  rsp_shown_in;
   logic [HOLD_W-1:0]     hold_count_ff;
   logic [HOLD_W-1:0]     hold_count_in;
   logic [HOLD_W-1:0]     hold_length_ff;
   logic                  enabled_ff;
   atog_geom_type         geom_ff;
   atog_geom_type         geom_in;
   logic                  advance;
   logic                  accept;
   logic                  csr_write;
   logic                  shown_now;
   logic                  trigger_load;
   logic [COLOR_W-1:0]    shade_color;
   logic [DIM_W-1:0]      dim_clamped;
   logic [DIM_W-1:0]      dim_start;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign shown_now = enabled_ff && (hold_count_ff != '0);
   assign trigger_load = advance && s1_valid_ff && (s1_action_ff == ACT_TRIGGER) &&
                         enabled_ff && !csr_valid;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_alert_shown = rsp_shown_ff;

   atog_pixel_shade u_shade (
      .geom        (geom_ff),
      .shown       (shown_now),
      .pixel_x     (s1_x_ff),
      .pixel_y     (s1_y_ff),
      .pixel_color (shade_color)
   );

   // Clamped size and text start for the dimension being written.
   always_comb begin
      dim_clamped = (32'(csr_wdata) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(csr_wdata);
      dim_start   = DIM_W'(MARGIN);
      if (csr_index == REG_AREA_WIDTH) begin
         if (dim_clamped >= DIM_W'(TEXT_W)) begin
            dim_start = (dim_clamped - DIM_W'(TEXT_W)) >> 1;
         end
      end else begin
         if (dim_clamped >= DIM_W'(TEXT_H)) begin
            dim_start = (dim_clamped - DIM_W'(TEXT_H)) >> 1;
         end
      end
      if (dim_start < DIM_W'(MARGIN)) begin
         dim_start = DIM_W'(MARGIN);
      end

      geom_in = geom_ff;
      if (csr_write && (csr_index == REG_AREA_WIDTH)) begin
         geom_in.width    = dim_clamped;
         geom_in.width_m1 = dim_clamped - DIM_W'(1);
         geom_in.start_x  = dim_start;
      end
      if (csr_write && (csr_index == REG_AREA_HEIGHT)) begin
         geom_in.height    = dim_clamped;
         geom_in.height_m1 = dim_clamped - DIM_W'(1);
         geom_in.start_y   = dim_start;
      end
   end

   always_comb begin
      hold_count_in = hold_count_ff;
      rsp_color_in  = COLOR_CLEAR;
      case (s1_action_ff)
         ACT_PIXEL: begin
            rsp_color_in = shade_color;
         end
         ACT_TRIGGER: begin
            if (enabled_ff) begin
               hold_count_in = hold_length_ff;
            end
         end
         ACT_TICK: begin
            if (enabled_ff && (hold_count_ff != '0)) begin
               hold_count_in = hold_count_ff - HOLD_W'(1);
            end
         end
         default: begin
            hold_count_in = hold_count_ff;
         end
      endcase
      rsp_shown_in = enabled_ff && (hold_count_in != '0);
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         hold_count_ff  <= '0;
         hold_length_ff <= RESET_HOLD;
         enabled_ff     <= 1'b0;
         geom_ff.width     <= RESET_WIDTH;
         geom_ff.height    <= RESET_HEIGHT;
         geom_ff.width_m1  <= RESET_WIDTH - DIM_W'(1);
         geom_ff.height_m1 <= RESET_HEIGHT - DIM_W'(1);
         geom_ff.start_x   <= (RESET_WIDTH >= DIM_W'(TEXT_W + 2 * MARGIN)) ?
                              (RESET_WIDTH - DIM_W'(TEXT_W)) >> 1 : DIM_W'(MARGIN);
         geom_ff.start_y   <= (RESET_HEIGHT >= DIM_W'(TEXT_H + 2 * MARGIN)) ?
                              (RESET_HEIGHT - DIM_W'(TEXT_H)) >> 1 : DIM_W'(MARGIN);
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         geom_ff      <= geom_in;
         if (csr_write && (csr_index == REG_HOLD_LENGTH)) begin
            hold_length_ff <= csr_wdata[HOLD_W-1:0];
         end
         if (csr_write && (csr_index == REG_ENABLED)) begin
            enabled_ff    <= csr_wdata[0];
            hold_count_ff <= '0;
         end else if (advance && s1_valid_ff) begin
            hold_count_ff <= hold_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_action;
         s1_x_ff      <= req_pixel_x;
         s1_y_ff      <= req_pixel_y;
      end
      if (advance && s1_valid_ff) begin
         rsp_color_ff <= rsp_color_in;
         rsp_shown_ff <= rsp_shown_in;
      end
   end

   `ASSERT_IMPLY(a_color_needs_banner, rsp_valid_ff && (rsp_color_ff != '0), rsp_shown_ff)
   `ASSERT_IMPLY(a_hold_needs_enable, hold_count_ff != '0, enabled_ff)
   `ASSERT_IMPLY(a_stall_when_full, req_stall, s1_valid_ff && rsp_valid_ff)
   `ASSERT_NEXT(a_trigger_loads, trigger_load, hold_count_ff == $past(hold_length_ff))

endmodule
